>>> design/qrr_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic real roots: shared types and constants
// Status codes and the stage-to-stage control bundle of the root pipeline.
// ----------------------------------------------------------------------------
package qrr_pkg;

   // Root status codes.
   localparam logic [1:0] ST_TWO    = 2'd0;
   localparam logic [1:0] ST_DOUBLE = 2'd1;
   localparam logic [1:0] ST_NONE   = 2'd2;
   localparam logic [1:0] ST_AZERO  = 2'd3;

   // Control bundle carried alongside each word through the pipeline.
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
   } ctl_type;

endpackage

>>> design/quadratic_real_roots_core.sv
// ----------------------------------------------------------------------------
// Quadratic real roots core
// Real roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Channel | Dir | Word
// req     | in  | tdata = {coef_c, coef_b, coef_a}
// rsp     | out | tdata = {root_plus, root_minus}, tuser = {saturated, root_status}
//
// One word enters per cycle while the output register is free or being taken. The
// path runs through the one-bit-per-stage square root and then the two
// one-bit-per-stage dividers, which run side by side.
// The whole pipeline advances only when its last stage is free or taken, so a
// stall freezes every stage and loses nothing. Reset clears the valid bits.
// ----------------------------------------------------------------------------
module quadratic_real_roots_core #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // coef_a [31:0], coef_b [63:32], coef_c [95:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // root_minus [31:0], root_plus [63:32]
   output logic [7:0]   rsp_tuser   // root_status [1:0], saturated [2], zeros above
);

   localparam int W   = WORD_BITS;
   localparam int PW  = 2 * W;           // magnitude product width
   localparam int DW  = PW + 4;          // discriminant width
   localparam int SW  = DW / 2;          // root width
   localparam int SQ_STAGES = SW;        // one root bit per stage
   localparam int NW  = SW + 2 + FRAC_BITS; // numerator width
   localparam int DV_STAGES = NW;        // one quotient bit per stage
   localparam int QW  = NW;
   localparam int NS  = SQ_STAGES + DV_STAGES + 5;

   // Single global advance enable.
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage 0: capture the coefficients.
   logic signed [W-1:0] a0_ff, b0_ff, c0_ff;
   qrr_pkg::ctl_type    k0_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         k0_ff <= '0;
      end else if (adv) begin
         k0_ff.valid  <= req_tvalid;
         k0_ff.status <= qrr_pkg::ST_TWO;
      end
      if (adv) begin
         a0_ff <= req_tdata[W-1:0];
         b0_ff <= req_tdata[32+W-1:32];
         c0_ff <= req_tdata[64+W-1:64];
      end
   end

   // Stage 1: magnitude products.
   logic [PW-1:0] p1_ff, m1_ff;
   logic          az1_ff, sd1_ff;
   logic signed [W-1:0] a1_ff, b1_ff;
   qrr_pkg::ctl_type    k1_ff;
   logic [W-1:0] mag_a, mag_b, mag_c;
   assign mag_a = a0_ff[W-1] ? W'(-a0_ff) : W'(a0_ff);
   assign mag_b = b0_ff[W-1] ? W'(-b0_ff) : W'(b0_ff);
   assign mag_c = c0_ff[W-1] ? W'(-c0_ff) : W'(c0_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= '0;
      end else if (adv) begin
         k1_ff <= k0_ff;
      end
      if (adv) begin
         p1_ff  <= PW'(mag_b) * PW'(mag_b);
         m1_ff  <= PW'(mag_a) * PW'(mag_c);
         az1_ff <= (a0_ff == '0);
         sd1_ff <= (a0_ff[W-1] != c0_ff[W-1]);
         a1_ff  <= a0_ff;
         b1_ff  <= b0_ff;
      end
   end

   // Stage 2: discriminant and status.
   logic [DW-1:0] d2_ff;
   logic signed [W-1:0] a2_ff, b2_ff;
   qrr_pkg::ctl_type    k2_ff;
   logic [DW-1:0] four_m, disc_sum, disc_dif;
   logic [1:0]    st2;
   assign four_m   = DW'(m1_ff) << 2;
   assign disc_sum = DW'(p1_ff) + four_m;
   assign disc_dif = DW'(p1_ff) - four_m;
   always_comb begin
      priority if (az1_ff) begin
         st2 = qrr_pkg::ST_AZERO;
      end else if (m1_ff == '0) begin
         st2 = (p1_ff == '0) ? qrr_pkg::ST_DOUBLE : qrr_pkg::ST_TWO;
      end else if (sd1_ff) begin
         st2 = qrr_pkg::ST_TWO;
      end else if (four_m > DW'(p1_ff)) begin
         st2 = qrr_pkg::ST_NONE;
      end else begin
         st2 = (disc_dif == '0) ? qrr_pkg::ST_DOUBLE : qrr_pkg::ST_TWO;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         k2_ff <= '0;
      end else if (adv) begin
         k2_ff.valid  <= k1_ff.valid;
         k2_ff.status <= st2;
      end
      if (adv) begin
         d2_ff <= (sd1_ff || m1_ff == '0) ? disc_sum : disc_dif;
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
      end
   end

   // Square root stages: two radicand bits per stage, one root bit out.
   logic [DW-1:0] sq_d_ff   [SQ_STAGES+1];
   logic [SW+1:0] sq_rem_ff [SQ_STAGES+1];
   logic [SW-1:0] sq_rt_ff  [SQ_STAGES+1];
   logic signed [W-1:0] sq_a_ff [SQ_STAGES+1];
   logic signed [W-1:0] sq_b_ff [SQ_STAGES+1];
   qrr_pkg::ctl_type    sq_k_ff [SQ_STAGES+1];
   always_comb begin
      sq_d_ff[0]   = d2_ff;
      sq_rem_ff[0] = '0;
      sq_rt_ff[0]  = '0;
      sq_a_ff[0]   = a2_ff;
      sq_b_ff[0]   = b2_ff;
      sq_k_ff[0]   = k2_ff;
   end
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      logic [SW+1:0] rem_in, trial_in;
      assign rem_in   = {sq_rem_ff[g][SW-1:0], sq_d_ff[g][DW-1 -: 2]};
      assign trial_in = {sq_rt_ff[g], 2'b01};
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_k_ff[g+1] <= '0;
         end else if (adv) begin
            sq_k_ff[g+1] <= sq_k_ff[g];
         end
         if (adv) begin
            sq_d_ff[g+1] <= sq_d_ff[g] << 2;
            if (rem_in >= trial_in) begin
               sq_rem_ff[g+1] <= rem_in - trial_in;
               sq_rt_ff[g+1]  <= {sq_rt_ff[g][SW-2:0], 1'b1};
            end else begin
               sq_rem_ff[g+1] <= rem_in;
               sq_rt_ff[g+1]  <= {sq_rt_ff[g][SW-2:0], 1'b0};
            end
            sq_a_ff[g+1] <= sq_a_ff[g];
            sq_b_ff[g+1] <= sq_b_ff[g];
         end
      end
   end

   // Numerator stage: signed numerators, magnitudes and quotient signs.
   localparam int SNW = SW + 2;
   logic [NW-1:0]  nm_ff, np_ff;
   logic [W:0]     den_ff;
   logic           sgm_ff, sgp_ff;
   qrr_pkg::ctl_type kn_ff;
   logic signed [SNW-1:0] negb, nmin, npls;
   assign negb = -SNW'(sq_b_ff[SQ_STAGES]);
   assign nmin = negb - SNW'({1'b0, sq_rt_ff[SQ_STAGES]});
   assign npls = negb + SNW'({1'b0, sq_rt_ff[SQ_STAGES]});
   logic [SNW-1:0] mag_nm, mag_np;
   logic [W-1:0]   mag_aq;
   logic           an;
   assign an     = sq_a_ff[SQ_STAGES][W-1];
   assign mag_nm = nmin[SNW-1] ? SNW'(-nmin) : SNW'(nmin);
   assign mag_np = npls[SNW-1] ? SNW'(-npls) : SNW'(npls);
   assign mag_aq = an ? W'(-sq_a_ff[SQ_STAGES]) : W'(sq_a_ff[SQ_STAGES]);
   always_ff @(posedge clock) begin
      if (reset) begin
         kn_ff <= '0;
      end else if (adv) begin
         kn_ff <= sq_k_ff[SQ_STAGES];
      end
      if (adv) begin
         nm_ff  <= NW'(mag_nm) << FRAC_BITS;
         np_ff  <= NW'(mag_np) << FRAC_BITS;
         den_ff <= {mag_aq, 1'b0};
         sgm_ff <= nmin[SNW-1] != an;
         sgp_ff <= npls[SNW-1] != an;
      end
   end

   // Dividers: restoring, one quotient bit per stage, both roots side by side.
   localparam int RW = W + 2;
   logic [NW-1:0] dm_n_ff [DV_STAGES+1], dp_n_ff [DV_STAGES+1];
   logic [RW-1:0] dm_r_ff [DV_STAGES+1], dp_r_ff [DV_STAGES+1];
   logic [W:0]    dv_d_ff [DV_STAGES+1];
   logic          dv_sm_ff [DV_STAGES+1], dv_sp_ff [DV_STAGES+1];
   qrr_pkg::ctl_type dv_k_ff [DV_STAGES+1];
   always_comb begin
      dm_n_ff[0]  = nm_ff;
      dp_n_ff[0]  = np_ff;
      dm_r_ff[0]  = '0;
      dp_r_ff[0]  = '0;
      dv_d_ff[0]  = den_ff;
      dv_sm_ff[0] = sgm_ff;
      dv_sp_ff[0] = sgp_ff;
      dv_k_ff[0]  = kn_ff;
   end
   for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
      logic [RW-1:0] rm, rp;
      assign rm = {dm_r_ff[g][RW-2:0], dm_n_ff[g][NW-1]};
      assign rp = {dp_r_ff[g][RW-2:0], dp_n_ff[g][NW-1]};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_k_ff[g+1] <= '0;
         end else if (adv) begin
            dv_k_ff[g+1] <= dv_k_ff[g];
         end
         if (adv) begin
            if (rm >= RW'(dv_d_ff[g])) begin
               dm_r_ff[g+1] <= rm - RW'(dv_d_ff[g]);
               dm_n_ff[g+1] <= {dm_n_ff[g][NW-2:0], 1'b1};
            end else begin
               dm_r_ff[g+1] <= rm;
               dm_n_ff[g+1] <= {dm_n_ff[g][NW-2:0], 1'b0};
            end
            if (rp >= RW'(dv_d_ff[g])) begin
               dp_r_ff[g+1] <= rp - RW'(dv_d_ff[g]);
               dp_n_ff[g+1] <= {dp_n_ff[g][NW-2:0], 1'b1};
            end else begin
               dp_r_ff[g+1] <= rp;
               dp_n_ff[g+1] <= {dp_n_ff[g][NW-2:0], 1'b0};
            end
            dv_d_ff[g+1]  <= dv_d_ff[g];
            dv_sm_ff[g+1] <= dv_sm_ff[g];
            dv_sp_ff[g+1] <= dv_sp_ff[g];
         end
      end
   end

   // Saturation and sign.
   localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (W - 1)) - 64'd1);
   localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (W - 1));
   function automatic logic [W:0] sat_root(input logic [QW-1:0] q, input logic neg);
      logic [W:0] res;
      res = '0;
      if (neg && q != '0) begin
         if (q > LIM_NEG) begin
            res = {1'b1, 1'b1, {(W-1){1'b0}}};
         end else begin
            res = {1'b0, W'(-q)};
         end
      end else begin
         if (q > LIM_POS) begin
            res = {1'b1, W'(LIM_POS)};
         end else begin
            res = {1'b0, W'(q)};
         end
      end
      return res;
   endfunction

   logic [W:0] sm, sp;
   assign sm = sat_root(dm_n_ff[DV_STAGES], dv_sm_ff[DV_STAGES]);
   assign sp = sat_root(dp_n_ff[DV_STAGES], dv_sp_ff[DV_STAGES]);

   // Output register.
   logic        vo_ff;
   logic [W-1:0] rm_ff, rp_ff;
   logic [1:0]  st_ff;
   logic        sat_ff;
   logic        has_roots;
   assign has_roots = dv_k_ff[DV_STAGES].status == qrr_pkg::ST_TWO
                   || dv_k_ff[DV_STAGES].status == qrr_pkg::ST_DOUBLE;
   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= dv_k_ff[DV_STAGES].valid;
      end
      if (adv) begin
         st_ff  <= dv_k_ff[DV_STAGES].status;
         rm_ff  <= has_roots ? sm[W-1:0] : '0;
         rp_ff  <= has_roots ? sp[W-1:0] : '0;
         sat_ff <= has_roots && (sm[W] || sp[W]);
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {32'(signed'(rp_ff)), 32'(signed'(rm_ff))};
   assign rsp_tuser  = {5'd0, sat_ff, st_ff};

   logic unused_ns;
   assign unused_ns = (NS > 0);

endmodule

>>> design/qrr_checker.sv
// ----------------------------------------------------------------------------
// Quadratic real roots port checker
// Watches the core's ports for result words that contradict their status.
// ----------------------------------------------------------------------------
module qrr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [7:0]  rsp_tuser
);

   // A result without real roots carries zero roots and no saturation.
   a_no_roots_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == qrr_pkg::ST_NONE
                  || rsp_tuser[1:0] == qrr_pkg::ST_AZERO)
      |-> rsp_tdata == '0 && !rsp_tuser[2])
      else $error("root fields set without real roots");

   // A double root has equal roots.
   a_double_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == qrr_pkg::ST_DOUBLE
      |-> rsp_tdata[31:0] == rsp_tdata[63:32])
      else $error("double root with unequal roots");

   // Input is taken whenever the output side is free.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                   && $stable(rsp_tuser))
      else $error("stalled result changed");

   logic unused_req;
   assign unused_req = req_tvalid;

endmodule

bind quadratic_real_roots_core qrr_checker u_qrr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> bench/tb_quadratic_real_roots_core.sv
// ----------------------------------------------------------------------------
// Quadratic real roots core testbench
// Streams coefficient words into the core and checks every root word against
// an in-bench root predictor. The sender and the receiver both stall at random.
// ----------------------------------------------------------------------------
module tb_quadratic_real_roots_core;

   typedef struct packed {
      logic [1:0]  status;
      logic        sat;
      logic [31:0] rplus;
      logic [31:0] rminus;
   } roots_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [7:0]   rsp_tuser;

   roots_type    roots_due[$];
   int           mismatches = 0;
   bit           hold_off = 1'b0;
   bit           no_stall = 1'b0;

   quadratic_real_roots_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Integer square root, rounded down, of a 68-bit value.
   function automatic logic [67:0] isqrt68(logic [67:0] v);
      logic [67:0] res;
      logic [67:0] bitv;
      logic [67:0] x;
      res = '0;
      x = v;
      bitv = 68'd1 << 66;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Truncated quotient num * 2^16 / (2a), clipped to 32 signed bits.
   function automatic logic [31:0] root_of(logic signed [67:0] num,
                                           logic signed [67:0] a, ref logic sat);
      logic [99:0] n;
      logic [99:0] d;
      logic [99:0] q;
      bit          neg;
      n = (num < 0) ? 100'(-num) : 100'(num);
      n = n << 16;
      d = (a < 0) ? 100'(-a) : 100'(a);
      d = d << 1;
      q = n / d;
      neg = ((num < 0) != (a < 0)) && (q != 0);
      if (neg) begin
         if (q > 100'h8000_0000) begin
            sat = 1'b1;
            q = 100'h8000_0000;
         end
         return 32'(-q);
      end
      if (q > 100'h7FFF_FFFF) begin
         sat = 1'b1;
         q = 100'h7FFF_FFFF;
      end
      return q[31:0];
   endfunction

   // Predicts the root word for one coefficient word.
   function automatic roots_type predict_roots(logic [31:0] ca, logic [31:0] cb,
                                               logic [31:0] cc);
      roots_type          r;
      logic signed [67:0] a;
      logic signed [67:0] b;
      logic signed [67:0] c;
      logic signed [67:0] disc;
      logic signed [67:0] s;
      logic               sat;
      r = '0;
      sat = 1'b0;
      a = 68'(signed'(ca));
      b = 68'(signed'(cb));
      c = 68'(signed'(cc));
      if (a == 0) begin
         r.status = qrr_pkg::ST_AZERO;
      end else begin
         disc = b * b - 4 * a * c;
         if (disc < 0) begin
            r.status = qrr_pkg::ST_NONE;
         end else begin
            r.status = (disc == 0) ? qrr_pkg::ST_DOUBLE : qrr_pkg::ST_TWO;
            s = isqrt68(disc);
            r.rminus = root_of(-b - s, a, sat);
            r.rplus = root_of(-b + s, a, sat);
            r.sat = sat;
         end
      end
      return r;
   endfunction

   // Sends one coefficient word and records its expected roots.
   task automatic send_word(logic [31:0] ca, logic [31:0] cb, logic [31:0] cc);
      req_tvalid <= 1'b1;
      req_tdata <= {cc, cb, ca};
      roots_due.push_back(predict_roots(ca, cb, cc));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'(signed'($urandom_range(0, 1024)) - 512) <<< 12;
         2: return 32'(signed'($urandom_range(0, 400)) - 200) <<< 16;
         3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         4: return 32'(signed'($urandom_range(0, 64)) - 32);
         default: return 32'($urandom()) >>> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] ext[6];
      ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      // Zero a, negative discriminant, double root, two roots, saturation.
      send_word(32'h0, 32'h0001_0000, 32'h0002_0000);
      send_word(32'h0001_0000, 32'h0, 32'h0001_0000);
      send_word(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
      send_word(32'h0001_0000, 32'h0, 32'hFFFF_0000);
      send_word(32'h0000_0001, 32'h7FFF_FFFF, 32'h0);
      send_word(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      for (int i = 0; i < 6; i++) send_word(ext[i], ext[5 - i], ext[(i + 3) % 6]);
      send_word(32'hFFFF_0000, 32'h0, 32'h0);
      pause_sender();
   endtask

   task automatic test_random(int count);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_word(rand_coef(), rand_coef(), rand_coef());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) pause_sender();
      end
      req_tvalid <= 1'b0;
   endtask

   // Holds the receiver off while the sender keeps offering words.
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         test_random(150);
      join
   endtask

   task automatic test_unstalled();
      no_stall = 1'b1;
      test_random(300);
      no_stall = 1'b0;
   endtask

   // Receiver stall pattern.
   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else if (no_stall) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 9) < 7);
   end

   // Compares each accepted root word with the oldest expectation.
   always @(posedge clock) begin
      roots_type exp_r;
      roots_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[1:0], rsp_tuser[2], rsp_tdata[63:32], rsp_tdata[31:0]};
         if (roots_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected root word %h", got);
         end else begin
            exp_r = roots_due.pop_front();
            if (got !== exp_r || rsp_tuser[7:3] !== 5'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: status %0d/%0d sat %0d/%0d minus %h/%h plus %h/%h",
                           exp_r.status, got.status, exp_r.sat, got.sat,
                           exp_r.rminus, got.rminus, exp_r.rplus, got.rplus);
            end
         end
      end
   end

   initial begin
      int waited;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(1100);
      test_unstalled();
      test_random(280);
      waited = 0;
      while (roots_due.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (120) @(posedge clock);
      if (mismatches == 0 && roots_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
